// ===== rtl/tswns_pkg.sv =====
package tswns_pkg;

  typedef enum logic [3:0] {
    REQ_ALLOC      = 4'd0,
    REQ_START      = 4'd1,
    REQ_SCHEDULE   = 4'd2,
    REQ_YIELD      = 4'd3,
    REQ_EXIT       = 4'd4,
    REQ_WAIT       = 4'd5,
    REQ_NOTIFY_ONE = 4'd6,
    REQ_NOTIFY_ALL = 4'd7,
    REQ_NOTIFY_ANY = 4'd8
  } req_e;

  typedef enum logic [2:0] {
    SLOT_UNUSED   = 3'd0,
    SLOT_EMBRYO   = 3'd1,
    SLOT_READY    = 3'd2,
    SLOT_RUNNING  = 3'd3,
    SLOT_SLEEPING = 3'd4,
    SLOT_ZOMBIE   = 3'd5
  } slot_st_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIX,
    S_SCAN,
    S_ONE,
    S_EXEC
  } state_e;

  localparam logic [1:0] RSP_OK      = 2'd0;
  localparam logic [1:0] RSP_NO_SLOT = 2'd1;
  localparam logic [1:0] RSP_NONE    = 2'd2;
  localparam logic [1:0] RSP_REJECT  = 2'd3;

  typedef struct packed {
    logic [3:0] req_type;
    logic [3:0] target_slot;
    logic [7:0] channel_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
    logic [4:0] alive_count;
  } rsp_t;

endpackage

// ===== rtl/thread_slot_wait_notify_scheduler.sv =====
// Yield, exit, wait and unknown requests pass through the execute state, notify one
// through its own state. Alloc and notify any scan until a hit or the last slot, start
// and notify all scan every slot, and schedule fixes the current slot before its scan;
// the scan checks one slot per cycle against the channel store. A new request is taken
// in the cycle the strobe shows. The receiver cannot stall; busy alone paces requests.
// Reset clears all slots to unused and not waiting; the channel store is not reset.
module thread_slot_wait_notify_scheduler #(
  parameter int SLOTS        = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  tswns_pkg::req_t   req_i,
  output logic              done_o,
  output tswns_pkg::rsp_t   rsp_o
);
  import tswns_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int AW = $clog2(SLOTS + 1);
  localparam int CB = CHANNEL_BITS;

  state_e                  state_q, state_d;
  slot_st_e                slot_st_q [SLOTS];
  slot_st_e                slot_st_d [SLOTS];
  logic [SLOTS-1:0]        wait_q, wait_d;
  logic [CB-1:0]           chan_mem [SLOTS];
  logic [CB-1:0]           mem_rd_q;
  logic                    mem_we;

  req_e                    req_q, req_d;
  logic [CB-1:0]           ch_q, ch_d;
  logic                    tgt_ok_q, tgt_ok_d;
  logic [IW-1:0]           idx_q, idx_d;
  logic [IW-1:0]           cnt_q, cnt_d;
  logic [IW-1:0]           cur_q, cur_d;
  logic                    has_q, has_d;
  logic [IW-1:0]           lw_q, lw_d;
  logic                    found_q, found_d;
  logic [IW-1:0]           first_q, first_d;
  logic [AW-1:0]           alive_q, alive_d;
  logic                    done_q, done_d;
  rsp_t                    rsp_q, rsp_d;

  logic [IW+3:0]           tgt_ext;
  logic [CB+7:0]           ch_ext;
  slot_st_e                st_idx, st_cur;
  logic                    match, last, hit, scan_end, run_ok;
  logic [1:0]              out_status;
  logic [IW-1:0]           out_slot;
  logic [IW+3:0]           slot_ext;
  logic [AW+4:0]           alive_ext;

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i);
    return (i == IW'(SLOTS - 1)) ? '0 : i + IW'(1);
  endfunction

  assign tgt_ext  = {{IW{1'b0}}, req_i.target_slot};
  assign ch_ext   = {{CB{1'b0}}, req_i.channel_id};
  assign st_idx   = slot_st_q[idx_q];
  assign st_cur   = slot_st_q[cur_q];
  assign match    = wait_q[idx_q] && (mem_rd_q == ch_q);
  assign last     = (cnt_q == IW'(SLOTS - 1));
  assign run_ok   = has_q && (st_cur == SLOT_RUNNING);

  always_comb begin
    case (req_q)
      REQ_ALLOC:      hit = (st_idx == SLOT_UNUSED);
      REQ_SCHEDULE:   hit = (st_idx == SLOT_READY);
      REQ_NOTIFY_ANY: hit = match;
      default:        hit = 1'b0;
    endcase
  end

  assign scan_end = hit || last;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (req_e'(req_i.req_type))
            REQ_SCHEDULE:   state_d = S_FIX;
            REQ_ALLOC, REQ_START, REQ_NOTIFY_ALL, REQ_NOTIFY_ANY: state_d = S_SCAN;
            REQ_NOTIFY_ONE: state_d = S_ONE;
            default:        state_d = S_EXEC;
          endcase
        end
      end
      S_FIX:  state_d = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_IDLE;
        end
      end
      S_ONE:  state_d = S_IDLE;
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and slot table updates.
  always_comb begin
    slot_st_d  = slot_st_q;
    wait_d     = wait_q;
    mem_we     = 1'b0;
    req_d      = req_q;
    ch_d       = ch_q;
    tgt_ok_d   = tgt_ok_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    has_d      = has_q;
    lw_d       = lw_q;
    found_d    = found_q;
    first_d    = first_q;
    alive_d    = alive_q;
    done_d     = 1'b0;
    out_status = RSP_OK;
    out_slot   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d    = req_e'(req_i.req_type);
          ch_d     = ch_ext[CB-1:0];
          tgt_ok_d = (tgt_ext < (IW+4)'(SLOTS));
          cnt_d    = '0;
          found_d  = 1'b0;
          first_d  = '0;
          unique case (req_e'(req_i.req_type))
            REQ_NOTIFY_ANY: idx_d = nxt_idx(lw_q);
            REQ_NOTIFY_ONE: idx_d = tgt_ext[IW-1:0];
            default:        idx_d = '0;
          endcase
        end
      end
      S_FIX: begin
        // A zombie is reclaimed; a slot still running is preempted.
        if (st_cur == SLOT_ZOMBIE) begin
          slot_st_d[cur_q] = SLOT_UNUSED;
          alive_d          = alive_q - AW'(1);
        end else if (run_ok) begin
          slot_st_d[cur_q] = SLOT_READY;
        end
        has_d = 1'b0;
        idx_d = nxt_idx(cur_q);
      end
      S_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        idx_d = nxt_idx(idx_q);
        case (req_q)
          REQ_ALLOC: begin
            if (hit) begin
              slot_st_d[idx_q] = SLOT_EMBRYO;
              wait_d[idx_q]    = 1'b0;
              alive_d          = alive_q + AW'(1);
              out_slot         = idx_q;
            end else begin
              out_status = RSP_NO_SLOT;
            end
          end
          REQ_START: begin
            if (st_idx == SLOT_EMBRYO) begin
              slot_st_d[idx_q] = SLOT_READY;
            end
          end
          REQ_SCHEDULE: begin
            if (hit) begin
              slot_st_d[idx_q] = SLOT_RUNNING;
              cur_d            = idx_q;
              has_d            = 1'b1;
              out_slot         = idx_q;
            end else begin
              out_status = RSP_NONE;
            end
          end
          REQ_NOTIFY_ALL: begin
            if (match) begin
              slot_st_d[idx_q] = SLOT_READY;
              wait_d[idx_q]    = 1'b0;
              found_d          = 1'b1;
              if (!found_q) begin
                first_d = idx_q;
              end
            end
            out_status = found_d ? RSP_OK : RSP_NONE;
            out_slot   = found_d ? first_d : '0;
          end
          REQ_NOTIFY_ANY: begin
            if (hit) begin
              slot_st_d[idx_q] = SLOT_READY;
              wait_d[idx_q]    = 1'b0;
              lw_d             = idx_q;
              out_slot         = idx_q;
            end else begin
              out_status = RSP_NONE;
            end
          end
          default: ;
        endcase
        done_d = scan_end;
      end
      S_ONE: begin
        if (tgt_ok_q && match) begin
          slot_st_d[idx_q] = SLOT_READY;
          wait_d[idx_q]    = 1'b0;
          out_slot         = idx_q;
        end else begin
          out_status = RSP_REJECT;
        end
        done_d = 1'b1;
      end
      S_EXEC: begin
        if (req_q == REQ_YIELD || req_q == REQ_EXIT || req_q == REQ_WAIT) begin
          if (run_ok) begin
            case (req_q)
              REQ_YIELD: slot_st_d[cur_q] = SLOT_READY;
              REQ_EXIT:  slot_st_d[cur_q] = SLOT_ZOMBIE;
              default: begin
                slot_st_d[cur_q] = SLOT_SLEEPING;
                wait_d[cur_q]    = 1'b1;
                mem_we           = 1'b1;
              end
            endcase
            has_d    = 1'b0;
            out_slot = cur_q;
          end else begin
            out_status = RSP_REJECT;
          end
        end
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign slot_ext  = {4'b0, out_slot};
  assign alive_ext = {5'b0, alive_d};

  always_comb begin
    rsp_d = rsp_q;
    if (done_d) begin
      rsp_d.status      = out_status;
      rsp_d.slot_index  = slot_ext[3:0];
      rsp_d.alive_count = alive_ext[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st_q[i] <= SLOT_UNUSED;
      end
      wait_q  <= '0;
      cur_q   <= '0;
      has_q   <= 1'b0;
      lw_q    <= IW'(SLOTS - 1);
      alive_q <= '0;
      done_q  <= 1'b0;
      req_q   <= REQ_ALLOC;
      cnt_q   <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      slot_st_q <= slot_st_d;
      wait_q    <= wait_d;
      cur_q     <= cur_d;
      has_q     <= has_d;
      lw_q      <= lw_d;
      alive_q   <= alive_d;
      done_q    <= done_d;
      req_q     <= req_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q     <= ch_d;
    tgt_ok_q <= tgt_ok_d;
    first_q  <= first_d;
    rsp_q    <= rsp_d;
  end

  // Channel store: one write port for wait, one registered read that runs one slot
  // ahead of the scan.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chan_mem[cur_q] <= ch_q;
    end
    mem_rd_q <= chan_mem[idx_d];
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/tswns_checker.sv =====
module tswns_checker #(
  parameter int SLOTS = 16
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input tswns_pkg::rsp_t rsp_o
);
  import tswns_pkg::*;

  // Every request taken makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken without going busy");

  // The result comes out exactly when the block returns to idle.
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("block went idle without a result");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // Alloc can only fail when every slot is in use.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == RSP_NO_SLOT |-> rsp_o.alive_count == 5'(SLOTS))
    else $error("alloc failed with a free slot");

endmodule

bind thread_slot_wait_notify_scheduler tswns_checker #(.SLOTS(SLOTS)) u_tswns_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
